FILE: sv/thbl_pkg.sv
// package for the toggle handshake byte link
// word types, phase codes and state record; no dependencies
`default_nettype none

package thbl_pkg;

    localparam logic       OP_TICK   = 1'b0;
    localparam logic       OP_START  = 1'b1;
    localparam logic [7:0] FIRST_BIT = 8'h80;

    typedef enum logic [2:0] {
        PH_UNSTARTED = 3'd0,
        PH_DONE_WR   = 3'd1,
        PH_RDY_RD    = 3'd2,
        PH_RDY_WR    = 3'd3,
        PH_READING   = 3'd4,
        PH_WRITING   = 3'd5
    } t_phase;

    typedef struct packed {
        logic       op;
        logic       in_level;
        logic       data_level;
        logic       tx_ready;
        logic [7:0] tx_byte;
    } t_in_word;

    typedef struct packed {
        logic       out_level;
        logic       data_drive;
        logic       data_value;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       tx_taken;
    } t_out_word;

    typedef struct packed {
        t_phase     phase;
        logic       seen_in_level;
        logic       notify_level;
        logic       driving;
        logic       drive_value;
        logic [7:0] shift_byte;
        logic [7:0] bit_mask;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:         PH_UNSTARTED,
        seen_in_level: 1'b0,
        notify_level:  1'b0,
        driving:       1'b0,
        drive_value:   1'b0,
        shift_byte:    8'h00,
        bit_mask:      8'h00
    };

endpackage

`default_nettype wire

FILE: sv/toggle_handshake_byte_link.sv
// toggle handshake byte link: the result word of an accepted input word is
// valid from the next clock edge on; throughput 1 word per cycle while the
// receiver takes results, set by the single-pass next-state logic and the
// result register; a waiting result is taken in the same cycle as a new word
// synchronous active-low reset puts the link unstarted with all lines released
// depends on thbl_pkg, thbl_step, thbl_out_reg
`default_nettype none

module toggle_handshake_byte_link (
    input  var logic                i_clk,
    input  var logic                i_rst_n,
    input  var logic                i_in_valid,
    output var logic                o_in_ready,
    input  var thbl_pkg::t_in_word  i_in_word,
    output var logic                o_out_valid,
    input  var logic                i_out_ready,
    output var thbl_pkg::t_out_word o_out_word
);

    thbl_pkg::t_state    r_state;
    thbl_pkg::t_state    n_state;
    thbl_pkg::t_out_word result;
    logic                free;
    logic                accept;

    assign o_in_ready = free;
    assign accept     = i_in_valid & free;

    thbl_step u_step (
        .i_state  (r_state),
        .i_word   (i_in_word),
        .o_next   (n_state),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= thbl_pkg::STATE_RESET;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    thbl_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_word  (result),
        .o_free  (free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

    a_mask_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_state.bit_mask))
        else $error("bit position not one-hot");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_word.op == thbl_pkg::OP_TICK
        && i_in_word.in_level == r_state.seen_in_level |=> $stable(r_state))
        else $error("state changed on tick without level change");

    a_taken_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.tx_taken |->
        o_out_word.data_drive && o_out_word.data_value)
        else $error("byte taken without driving start bit");

    a_rx_listen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.rx_valid |-> !o_out_word.data_drive)
        else $error("byte delivered while driving the data line");

endmodule

`default_nettype wire

FILE: sv/thbl_step.sv
// next-state and result logic for one word of the byte link
// depends on thbl_pkg
`default_nettype none

module thbl_step (
    input  var thbl_pkg::t_state    i_state,
    input  var thbl_pkg::t_in_word  i_word,
    output var thbl_pkg::t_state    o_next,
    output var thbl_pkg::t_out_word o_result
);

    function automatic thbl_pkg::t_state choose_role(
        input thbl_pkg::t_state s,
        input logic             level
    );
        thbl_pkg::t_state r;
        r = s;
        if (level) begin
            r.driving = 1'b0;
            r.phase   = thbl_pkg::PH_RDY_RD;
        end else begin
            r.driving      = 1'b1;
            r.drive_value  = 1'b0;
            r.notify_level = 1'b1;
            r.phase        = thbl_pkg::PH_DONE_WR;
        end
        return r;
    endfunction

    thbl_pkg::t_state s;
    logic             rxv;
    logic [7:0]       rxb;
    logic             taken;
    logic [7:0]       shifted;

    assign shifted = i_state.bit_mask >> 1;

    always_comb begin
        s     = i_state;
        rxv   = 1'b0;
        rxb   = 8'h00;
        taken = 1'b0;
        if (i_word.op == thbl_pkg::OP_START) begin
            s = choose_role(i_state, i_word.in_level);
        end else if (i_word.in_level != i_state.seen_in_level) begin
            s.seen_in_level = i_word.in_level;
            case (i_state.phase)
                thbl_pkg::PH_UNSTARTED: begin
                    s = choose_role(s, i_word.in_level);
                end
                thbl_pkg::PH_DONE_WR: begin
                    s.driving = 1'b0;
                    s.phase   = thbl_pkg::PH_RDY_RD;
                end
                thbl_pkg::PH_RDY_RD: begin
                    if (i_word.data_level) begin
                        s.shift_byte = 8'h00;
                        s.bit_mask   = thbl_pkg::FIRST_BIT;
                        s.phase      = thbl_pkg::PH_READING;
                    end else begin
                        s.phase = thbl_pkg::PH_RDY_WR;
                    end
                end
                thbl_pkg::PH_RDY_WR: begin
                    s.driving = 1'b1;
                    if (i_word.tx_ready) begin
                        s.shift_byte  = i_word.tx_byte;
                        s.drive_value = 1'b1;
                        s.bit_mask    = thbl_pkg::FIRST_BIT;
                        taken         = 1'b1;
                        s.phase       = thbl_pkg::PH_WRITING;
                    end else begin
                        s.drive_value = 1'b0;
                        s.phase       = thbl_pkg::PH_DONE_WR;
                    end
                end
                thbl_pkg::PH_READING: begin
                    if (i_word.data_level) begin
                        s.shift_byte = i_state.shift_byte | i_state.bit_mask;
                    end
                    s.bit_mask = shifted;
                    if (shifted == 8'h00) begin
                        s.phase = thbl_pkg::PH_RDY_RD;
                        rxv     = 1'b1;
                        rxb     = s.shift_byte;
                    end
                end
                thbl_pkg::PH_WRITING: begin
                    s.drive_value = |(i_state.bit_mask & i_state.shift_byte);
                    s.bit_mask    = shifted;
                    if (shifted == 8'h00) begin
                        s.phase = thbl_pkg::PH_RDY_WR;
                    end
                end
                default: begin
                end
            endcase
            s.notify_level = ~s.notify_level;
        end
    end

    assign o_next              = s;
    assign o_result.out_level  = s.notify_level;
    assign o_result.data_drive = s.driving;
    assign o_result.data_value = s.driving & s.drive_value;
    assign o_result.rx_valid   = rxv;
    assign o_result.rx_byte    = rxb;
    assign o_result.tx_taken   = taken;

endmodule

`default_nettype wire

FILE: sv/thbl_out_reg.sv
// result register with valid/ready handshake for the byte link
// depends on thbl_pkg
`default_nettype none

module thbl_out_reg (
    input  var logic                i_clk,
    input  var logic                i_rst_n,
    input  var logic                i_load,
    input  var thbl_pkg::t_out_word i_word,
    output var logic                o_free,
    output var logic                o_valid,
    input  var logic                i_ready,
    output var thbl_pkg::t_out_word o_word
);

    logic                r_valid;
    logic                n_valid;
    thbl_pkg::t_out_word r_word;

    assign o_free  = ~r_valid | i_ready;
    assign n_valid = i_load | (r_valid & ~i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

FILE: dv/toggle_handshake_byte_link_tb.sv
// testbench for the toggle handshake byte link: directed and random words,
// checked against an in-bench prediction of the link's phase machine
// depends on thbl_pkg and toggle_handshake_byte_link
`default_nettype none

module toggle_handshake_byte_link_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         DRAIN_LIMIT = 50000;
    localparam logic [7:0] RX_PATTERN  = 8'hA5;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    thbl_pkg::t_in_word  i_in_word = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    thbl_pkg::t_out_word o_out_word;

    thbl_pkg::t_in_word  pending_words[$];
    thbl_pkg::t_out_word expected_words[$];
    thbl_pkg::t_state    link_state = thbl_pkg::STATE_RESET;
    thbl_pkg::t_out_word want;
    logic      partner_level = 1'b0;
    logic      in_fired = 1'b0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        hold_left = 0;
    int        cycle_count = 0;
    int        mismatch_count = 0;
    int        words_checked = 0;
    int        bytes_received = 0;
    int        bytes_sent = 0;

    toggle_handshake_byte_link dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("mismatch %s: got %0h, expected %0h", what, got, exp_val);
        mismatch_count++;
    endtask

    function automatic void pick_role(input logic lvl);
        if (lvl) begin
            link_state.driving = 1'b0;
            link_state.phase   = thbl_pkg::PH_RDY_RD;
        end else begin
            link_state.driving      = 1'b1;
            link_state.drive_value  = 1'b0;
            link_state.notify_level = 1'b1;
            link_state.phase        = thbl_pkg::PH_DONE_WR;
        end
    endfunction

    function automatic thbl_pkg::t_out_word predict_link(input thbl_pkg::t_in_word w);
        thbl_pkg::t_out_word r;
        r = '0;
        if (w.op == thbl_pkg::OP_START) begin
            pick_role(w.in_level);
        end else if (w.in_level != link_state.seen_in_level) begin
            link_state.seen_in_level = w.in_level;
            case (link_state.phase)
                thbl_pkg::PH_UNSTARTED: pick_role(w.in_level);
                thbl_pkg::PH_DONE_WR: begin
                    link_state.driving = 1'b0;
                    link_state.phase   = thbl_pkg::PH_RDY_RD;
                end
                thbl_pkg::PH_RDY_RD: begin
                    if (w.data_level) begin
                        link_state.shift_byte = 8'h00;
                        link_state.bit_mask   = thbl_pkg::FIRST_BIT;
                        link_state.phase      = thbl_pkg::PH_READING;
                    end else begin
                        link_state.phase = thbl_pkg::PH_RDY_WR;
                    end
                end
                thbl_pkg::PH_RDY_WR: begin
                    link_state.driving = 1'b1;
                    if (w.tx_ready) begin
                        link_state.shift_byte  = w.tx_byte;
                        link_state.drive_value = 1'b1;
                        link_state.bit_mask    = thbl_pkg::FIRST_BIT;
                        link_state.phase       = thbl_pkg::PH_WRITING;
                        r.tx_taken             = 1'b1;
                    end else begin
                        link_state.drive_value = 1'b0;
                        link_state.phase       = thbl_pkg::PH_DONE_WR;
                    end
                end
                thbl_pkg::PH_READING: begin
                    if (w.data_level) begin
                        link_state.shift_byte = link_state.shift_byte | link_state.bit_mask;
                    end
                    link_state.bit_mask = link_state.bit_mask >> 1;
                    if (link_state.bit_mask == 8'h00) begin
                        link_state.phase = thbl_pkg::PH_RDY_RD;
                        r.rx_valid       = 1'b1;
                        r.rx_byte        = link_state.shift_byte;
                    end
                end
                thbl_pkg::PH_WRITING: begin
                    link_state.drive_value = |(link_state.bit_mask & link_state.shift_byte);
                    link_state.bit_mask    = link_state.bit_mask >> 1;
                    if (link_state.bit_mask == 8'h00) begin
                        link_state.phase = thbl_pkg::PH_RDY_WR;
                    end
                end
                default: ;
            endcase
            link_state.notify_level = ~link_state.notify_level;
        end
        r.out_level  = link_state.notify_level;
        r.data_drive = link_state.driving;
        r.data_value = link_state.driving & link_state.drive_value;
        return r;
    endfunction

    // word source
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fired) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_word  <= pending_words.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= i_rst_n && hold_left == 0 && $urandom_range(99) >= stall_pct;
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // prediction on acceptance, check on delivery
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else if (!i_rst_n) begin
            in_fired   <= 1'b0;
            link_state = thbl_pkg::STATE_RESET;
        end else begin
            in_fired <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                expected_words.push_back(predict_link(i_in_word));
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", int'(o_out_word), 0);
                end else begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (want.rx_valid) bytes_received++;
                    if (want.tx_taken) bytes_sent++;
                    if (o_out_word.out_level !== want.out_level)
                        report_mismatch("out_level", int'(o_out_word.out_level),
                                        int'(want.out_level));
                    if (o_out_word.data_drive !== want.data_drive)
                        report_mismatch("data_drive", int'(o_out_word.data_drive),
                                        int'(want.data_drive));
                    if (o_out_word.data_value !== want.data_value)
                        report_mismatch("data_value", int'(o_out_word.data_value),
                                        int'(want.data_value));
                    if (o_out_word.rx_valid !== want.rx_valid)
                        report_mismatch("rx_valid", int'(o_out_word.rx_valid),
                                        int'(want.rx_valid));
                    if (o_out_word.rx_byte !== want.rx_byte)
                        report_mismatch("rx_byte", int'(o_out_word.rx_byte),
                                        int'(want.rx_byte));
                    if (o_out_word.tx_taken !== want.tx_taken)
                        report_mismatch("tx_taken", int'(o_out_word.tx_taken),
                                        int'(want.tx_taken));
                end
            end
        end
    end

    task automatic add_word(input logic op, input logic lvl, input logic dat,
                            input logic rdy, input logic [7:0] txb);
        thbl_pkg::t_in_word w;
        w.op         = op;
        w.in_level   = lvl;
        w.data_level = dat;
        w.tx_ready   = rdy;
        w.tx_byte    = txb;
        if (op == thbl_pkg::OP_TICK) partner_level = lvl;
        pending_words.push_back(w);
    endtask

    // mostly notified ticks from a well-behaved partner, with a few starts
    task automatic queue_random(input int count);
        int roll;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
                add_word(thbl_pkg::OP_START, 1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), 8'($urandom_range(255)));
            end else begin
                add_word(thbl_pkg::OP_TICK, partner_level ^ ($urandom_range(99) < 80),
                         1'($urandom_range(1)), $urandom_range(99) < 70,
                         8'($urandom_range(255)));
            end
        end
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while ((pending_words.size() != 0 || i_in_valid || expected_words.size() != 0)
               && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        add_word(thbl_pkg::OP_TICK, 1'b0, 1'b0, 1'b0, 8'h00);
        add_word(thbl_pkg::OP_TICK, 1'b1, 1'b0, 1'b0, 8'h00);
        add_word(thbl_pkg::OP_TICK, 1'b0, 1'b1, 1'b0, 8'h00);
        for (int b = 7; b >= 0; b--) begin
            add_word(thbl_pkg::OP_TICK, !partner_level, RX_PATTERN[b], 1'b1, 8'h00);
        end
        add_word(thbl_pkg::OP_TICK, !partner_level, 1'b0, 1'b0, 8'h00);
        add_word(thbl_pkg::OP_TICK, !partner_level, 1'b0, 1'b1, 8'hFF);
        for (int b = 0; b < 8; b++) begin
            add_word(thbl_pkg::OP_TICK, !partner_level, 1'b1, 1'b0, 8'h00);
        end
        add_word(thbl_pkg::OP_TICK, !partner_level, 1'b0, 1'b0, 8'h3C);
        add_word(thbl_pkg::OP_START, 1'b0, 1'b1, 1'b1, 8'hFF);
        add_word(thbl_pkg::OP_START, 1'b1, 1'b0, 1'b0, 8'h00);
        add_word(thbl_pkg::OP_TICK, partner_level, 1'b1, 1'b1, 8'hAA);
        queue_random(120);
        wait_drained();

        send_idle_pct = 58;
        queue_random(120);
        wait_drained();

        send_idle_pct = 0;
        stall_pct     = 58;
        queue_random(120);
        wait_drained();

        // sender pauses half way until everything is back
        send_idle_pct = 25;
        stall_pct     = 25;
        queue_random(60);
        wait_drained();
        queue_random(60);
        wait_drained();

        // receiver holds off while words keep coming
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 300;
        queue_random(60);
        wait_drained();

        repeat (5) @(negedge i_clk);
        if (expected_words.size() != 0) begin
            report_mismatch("words left over", expected_words.size(), 0);
        end
        $display("checked %0d words: %0d bytes received, %0d bytes sent, %0d mismatches",
                 words_checked, bytes_received, bytes_sent, mismatch_count);
        $display("idling phases: none, sender, receiver, both, long receiver hold-off");
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
